>>> hw/rtl/pdrs_pkg.sv
`default_nettype none
package pdrs_pkg;

  localparam int MAX_FACTORS = 12;
  localparam int VAL_W       = 38;
  localparam int TRIAL_W     = 20;
  localparam int SQ_W        = 40;
  localparam int MOD_W       = 14;
  localparam int EXP_W       = 6;
  localparam int CNT_W       = 4;
  localparam int STEP_W      = 6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_TGT,
    S_FTEST,
    S_FDIV,
    S_FTAIL,
    S_EGO,
    S_EMOD,
    S_ESCAN,
    S_EMUL,
    S_ESWEEP,
    S_ECOF
  } state_t;

  typedef enum logic [2:0] {
    DIV_TARGET,
    DIV_TRIAL,
    DIV_REDIV,
    DIV_MODM,
    DIV_COF
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     set_target;
    logic     fact_init;
    logic     fact_take;
    logic     fact_next;
    logic     fact_tail;
    logic     enum_init;
    logic     scan_init;
    logic     scan_zero;
    logic     scan_inc;
    logic     mul_store;
    logic     sweep_step;
    logic     out_hit;
    logic     out_miss;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic mn_zero;
    logic sq_gt_rem;
    logic rem_zero;
    logic mod_hit;
    logic idx_zero;
    logic can_inc;
    logic sweep_end;
  } status_t;

endpackage
`default_nettype wire

>>> hw/rtl/pdrs_divider.sv
`default_nettype none
module pdrs_divider
  import pdrs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [VAL_W-1:0] dividend,
  input  wire logic [VAL_W-1:0] divisor,
  output logic      [VAL_W-1:0] quotient,
  output logic      [VAL_W-1:0] remainder,
  output logic                  done
);

  logic              running;
  logic [STEP_W-1:0] count;
  logic [VAL_W-1:0]  dvs;
  logic [VAL_W:0]    trial;
  logic [VAL_W-1:0]  rem_next;
  logic              qbit;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {remainder, quotient[VAL_W-1]};
    if (trial >= {1'b0, dvs}) begin
      qbit     = 1'b1;
      rem_next = VAL_W'(trial - {1'b0, dvs});
    end else begin
      qbit     = 1'b0;
      rem_next = trial[VAL_W-1:0];
    end
  end

  // iterate one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient  <= dividend;
        remainder <= '0;
        dvs       <= divisor;
        count     <= STEP_W'(VAL_W);
        running   <= 1'b1;
      end else if (running) begin
        remainder <= rem_next;
        quotient  <= {quotient[VAL_W-2:0], qbit};
        count     <= count - 1'b1;
        if (count == STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    done |-> remainder < dvs) else $error("divider remainder not reduced");
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    start |=> running && !done) else $error("divider did not start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !running) else $error("divider finished while still running");

endmodule
`default_nettype wire

>>> hw/rtl/pdrs_multiplier.sv
`default_nettype none
module pdrs_multiplier
  import pdrs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [VAL_W-1:0] op_a,
  input  wire logic [VAL_W-1:0] op_b,
  output logic      [VAL_W-1:0] product,
  output logic                  done
);

  logic              running;
  logic [STEP_W-1:0] count;
  logic [VAL_W-1:0]  mcand;
  logic [VAL_W-1:0]  mplier;

  // shift and add, one multiplier bit per cycle, low word kept
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mcand   <= op_a;
        mplier  <= op_b;
        product <= '0;
        count   <= STEP_W'(VAL_W);
        running <= 1'b1;
      end else if (running) begin
        if (mplier[0]) begin
          product <= product + mcand;
        end
        mcand  <= {mcand[VAL_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[VAL_W-1:1]};
        count  <= count - 1'b1;
        if (count == STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/pdrs_datapath.sv
`default_nettype none
module pdrs_datapath
  import pdrs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cmd_t             cmd,
  input  wire logic [31:0]      prime_value,
  input  wire logic [5:0]       pair_first,
  input  wire logic [5:0]       pair_second,
  output status_t               status,
  output logic                  done,
  output logic                  found,
  output logic      [VAL_W-1:0] divisor,
  output logic      [VAL_W-1:0] cofactor
);

  logic [31:0]        prime_in;
  logic [VAL_W-1:0]   n_val;
  logic [MOD_W-1:0]   modulus;
  logic [MOD_W-1:0]   target;
  logic [VAL_W-1:0]   remainder_value;
  logic [TRIAL_W-1:0] trial_divisor;
  logic [SQ_W-1:0]    trial_square;
  logic [EXP_W-1:0]   exp_run;
  logic [CNT_W-1:0]   factor_count;
  logic [VAL_W-1:0]   factor_prime    [MAX_FACTORS];
  logic [EXP_W-1:0]   factor_exponent [MAX_FACTORS];
  logic [EXP_W-1:0]   exponent_digit  [MAX_FACTORS];
  logic [VAL_W-1:0]   partial_product [MAX_FACTORS];
  logic [VAL_W-1:0]   current_product;
  logic [CNT_W-1:0]   scan_idx;
  logic [CNT_W-1:0]   sweep_idx;
  logic [CNT_W-1:0]   sidx;

  logic [VAL_W-1:0]   bp;
  logic [11:0]        ab;
  logic [VAL_W-1:0]   div_dd;
  logic [VAL_W-1:0]   div_dv;
  logic [VAL_W-1:0]   div_quo;
  logic [VAL_W-1:0]   div_rem;
  logic               div_done;
  logic [VAL_W-1:0]   mul_prod;
  logic               mul_done;
  logic               room;

  assign bp   = pair_second * prime_value;
  assign ab   = pair_first * pair_second;
  assign sidx = scan_idx - 1'b1;
  assign room = factor_count < CNT_W'(MAX_FACTORS);

  // pick the operands of the shared divider
  always_comb begin
    case (cmd.div_sel)
      DIV_TARGET: begin
        div_dd = {6'd0, prime_in};
        div_dv = {{(VAL_W-MOD_W){1'b0}}, modulus};
      end
      DIV_TRIAL: begin
        div_dd = remainder_value;
        div_dv = {{(VAL_W-TRIAL_W){1'b0}}, trial_divisor};
      end
      DIV_REDIV: begin
        div_dd = div_quo;
        div_dv = {{(VAL_W-TRIAL_W){1'b0}}, trial_divisor};
      end
      DIV_MODM: begin
        div_dd = current_product;
        div_dv = {{(VAL_W-MOD_W){1'b0}}, modulus};
      end
      DIV_COF: begin
        div_dd = n_val;
        div_dv = current_product;
      end
      default: begin
        div_dd = '0;
        div_dv = '0;
      end
    endcase
  end

  pdrs_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dd),
    .divisor   (div_dv),
    .quotient  (div_quo),
    .remainder (div_rem),
    .done      (div_done)
  );

  pdrs_multiplier u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.scan_inc),
    .op_a    (partial_product[sidx]),
    .op_b    (factor_prime[sidx]),
    .product (mul_prod),
    .done    (mul_done)
  );

  // report to the controller
  always_comb begin
    status.div_done  = div_done;
    status.mul_done  = mul_done;
    status.mn_zero   = (modulus == '0) || (n_val == '0);
    status.sq_gt_rem = trial_square > {{(SQ_W-VAL_W){1'b0}}, remainder_value};
    status.rem_zero  = div_rem == '0;
    status.mod_hit   = div_rem == {{(VAL_W-MOD_W){1'b0}}, target};
    status.idx_zero  = scan_idx == '0;
    status.can_inc   = exponent_digit[sidx] < factor_exponent[sidx];
    status.sweep_end = sweep_idx >= factor_count;
  end

  // working registers of factoring and divisor walk
  always_ff @(posedge clk) begin
    if (rst) begin
      factor_count    <= '0;
      remainder_value <= '0;
      trial_divisor   <= TRIAL_W'(2);
      trial_square    <= SQ_W'(4);
      current_product <= VAL_W'(1);
      exp_run         <= '0;
      scan_idx        <= '0;
      sweep_idx       <= '0;
    end else begin
      if (cmd.load) begin
        prime_in <= prime_value;
        n_val    <= bp + {{(VAL_W-6){1'b0}}, pair_first};
        modulus  <= {ab, 2'b00};
      end
      if (cmd.set_target) begin
        target <= (div_rem == '0) ? '0 : modulus - div_rem[MOD_W-1:0];
      end
      if (cmd.fact_init) begin
        remainder_value <= n_val;
        trial_divisor   <= TRIAL_W'(2);
        trial_square    <= SQ_W'(4);
        exp_run         <= '0;
        factor_count    <= '0;
      end
      if (cmd.fact_take) begin
        remainder_value <= div_quo;
        exp_run         <= exp_run + 1'b1;
      end
      // record a trial divisor that divided, then go 2, 3, 5, 7, 9
      if (cmd.fact_next) begin
        if (exp_run != '0 && room) begin
          factor_prime[factor_count]    <= {{(VAL_W-TRIAL_W){1'b0}}, trial_divisor};
          factor_exponent[factor_count] <= exp_run;
          factor_count                  <= factor_count + 1'b1;
        end
        exp_run <= '0;
        if (trial_divisor == TRIAL_W'(2)) begin
          trial_divisor <= TRIAL_W'(3);
          trial_square  <= SQ_W'(9);
        end else begin
          trial_divisor <= trial_divisor + TRIAL_W'(2);
          trial_square  <= trial_square
                         + {{(SQ_W-TRIAL_W-2){1'b0}}, trial_divisor, 2'b00} + SQ_W'(4);
        end
      end
      // leftover above one is the last prime
      if (cmd.fact_tail && remainder_value > VAL_W'(1) && room) begin
        factor_prime[factor_count]    <= remainder_value;
        factor_exponent[factor_count] <= EXP_W'(1);
        factor_count                  <= factor_count + 1'b1;
      end
      if (cmd.enum_init) begin
        for (int i = 0; i < MAX_FACTORS; i++) begin
          exponent_digit[i]  <= '0;
          partial_product[i] <= VAL_W'(1);
        end
        current_product <= VAL_W'(1);
      end
      if (cmd.scan_init) begin
        scan_idx <= factor_count;
      end
      if (cmd.scan_zero) begin
        exponent_digit[sidx] <= '0;
        scan_idx             <= sidx;
      end
      if (cmd.scan_inc) begin
        exponent_digit[sidx] <= exponent_digit[sidx] + 1'b1;
      end
      if (cmd.mul_store) begin
        partial_product[sidx] <= mul_prod;
        current_product       <= mul_prod;
        sweep_idx             <= scan_idx;
      end
      // copy the new prefix product into the cleared lower digits
      if (cmd.sweep_step) begin
        partial_product[sweep_idx] <= current_product;
        sweep_idx                  <= sweep_idx + 1'b1;
      end
    end
  end

  // result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.out_hit | cmd.out_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_hit) begin
      found    <= 1'b1;
      divisor  <= current_product;
      cofactor <= div_quo;
    end else if (cmd.out_miss) begin
      found    <= 1'b0;
      divisor  <= '0;
      cofactor <= '0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    factor_count <= CNT_W'(MAX_FACTORS)) else $error("factor table overrun");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");
  a_hit_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && found |-> divisor != '0 && cofactor != '0) else $error("empty hit");

endmodule
`default_nettype wire

>>> hw/rtl/pdrs_controller.sv
`default_nettype none
module pdrs_controller
  import pdrs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire status_t status,
  output logic         busy,
  output cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequence target, trial division, then the divisor walk
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = state != S_IDLE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.mn_zero) begin
          cmd.out_miss = 1'b1;
          state_next   = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_TARGET;
          state_next    = S_TGT;
        end
      end
      S_TGT: begin
        if (status.div_done) begin
          cmd.set_target = 1'b1;
          cmd.fact_init  = 1'b1;
          state_next     = S_FTEST;
        end
      end
      S_FTEST: begin
        if (status.sq_gt_rem) begin
          state_next = S_FTAIL;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_TRIAL;
          state_next    = S_FDIV;
        end
      end
      S_FDIV: begin
        if (status.div_done) begin
          if (status.rem_zero) begin
            cmd.fact_take = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_REDIV;
          end else begin
            cmd.fact_next = 1'b1;
            state_next    = S_FTEST;
          end
        end
      end
      S_FTAIL: begin
        cmd.fact_tail = 1'b1;
        cmd.enum_init = 1'b1;
        state_next    = S_EGO;
      end
      S_EGO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_MODM;
        state_next    = S_EMOD;
      end
      S_EMOD: begin
        if (status.div_done) begin
          if (status.mod_hit) begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_COF;
            state_next    = S_ECOF;
          end else begin
            cmd.scan_init = 1'b1;
            state_next    = S_ESCAN;
          end
        end
      end
      S_ESCAN: begin
        if (status.idx_zero) begin
          cmd.out_miss = 1'b1;
          state_next   = S_IDLE;
        end else if (status.can_inc) begin
          cmd.scan_inc = 1'b1;
          state_next   = S_EMUL;
        end else begin
          cmd.scan_zero = 1'b1;
        end
      end
      S_EMUL: begin
        if (status.mul_done) begin
          cmd.mul_store = 1'b1;
          state_next    = S_ESWEEP;
        end
      end
      S_ESWEEP: begin
        if (status.sweep_end) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_MODM;
          state_next    = S_EMOD;
        end else begin
          cmd.sweep_step = 1'b1;
        end
      end
      S_ECOF: begin
        if (status.div_done) begin
          cmd.out_hit = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/pair_divisor_residue_search_unit.sv
`default_nettype none
// Takes p, a and b when start is high and busy is low, forms N = a + b*p and
// m = 4ab, factors N by trial division (2, then odd numbers) and walks its
// divisors until one is congruent to -p mod m. One item at a time: the work
// is set by a bit-serial divider, used once for the target, once for every
// trial divisor up to the square root of what is left of N and once more for
// each division a found factor needs (up to about 2^18 trials for a large
// prime N), then per divisor visited once for the residue check, beside a
// shift-add multiply and a short table update, and once more for the
// cofactor on a hit. Items with a or b zero, or N zero, hold busy for one
// cycle and report a miss. The result appears on found, divisor and cofactor
// with done high for exactly one cycle, in the first cycle in which busy is
// low again; it must be taken then, as it cannot be held off.
module pair_divisor_residue_search_unit
  import pdrs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [31:0]      prime_value,
  input  wire logic [5:0]       pair_first,
  input  wire logic [5:0]       pair_second,
  output logic                  done,
  output logic                  found,
  output logic      [VAL_W-1:0] divisor,
  output logic      [VAL_W-1:0] cofactor
);

  cmd_t    cmd;
  status_t status;

  pdrs_controller u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  pdrs_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .prime_value (prime_value),
    .pair_first  (pair_first),
    .pair_second (pair_second),
    .status      (status),
    .done        (done),
    .found       (found),
    .divisor     (divisor),
    .cofactor    (cofactor)
  );

endmodule
`default_nettype wire

>>> sim/pair_divisor_residue_search_checker.sv
`timescale 1ns / 1ps
module pair_divisor_residue_search_checker
  import pdrs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             busy,
  input  wire logic [31:0]      prime_value,
  input  wire logic [5:0]       pair_first,
  input  wire logic [5:0]       pair_second,
  input  wire logic             done,
  input  wire logic             found,
  input  wire logic [VAL_W-1:0] divisor,
  input  wire logic [VAL_W-1:0] cofactor,
  output int                    fail_count,
  output int                    pending
);

  typedef struct {
    logic             hit;
    logic [VAL_W-1:0] k;
    logic [VAL_W-1:0] cof;
  } match_t;

  match_t expected_matches[$];

  // Factor n = a + b*p and walk its divisors until one is congruent to -p mod 4ab
  function automatic match_t search_match(input logic [31:0] p, input logic [5:0] a,
                                          input logic [5:0] b);
    longint unsigned n, m, tgt, rest, d, prod;
    longint unsigned primes [MAX_FACTORS];
    int              powers [MAX_FACTORS];
    int              digits [MAX_FACTORS];
    int              count, e, pos, i, j;
    match_t          r;
    r.hit = 1'b0;
    r.k = '0;
    r.cof = '0;
    n = longint'(a) + longint'(b) * longint'(p);
    m = 4 * longint'(a) * longint'(b);
    if (m == 0 || n == 0) return r;
    tgt = (m - (longint'(p) % m)) % m;
    // trial division by 2, then odd numbers
    count = 0;
    rest = n;
    d = 2;
    while (d * d <= rest) begin
      if (rest % d == 0) begin
        e = 0;
        while (rest % d == 0) begin
          rest = rest / d;
          e++;
        end
        if (count < MAX_FACTORS) begin
          primes[count] = d;
          powers[count] = e;
          count++;
        end
      end
      d = (d == 2) ? 3 : d + 2;
    end
    if (rest > 1 && count < MAX_FACTORS) begin
      primes[count] = rest;
      powers[count] = 1;
      count++;
    end
    for (i = 0; i < count; i++) digits[i] = 0;
    // first prime is the most significant digit
    forever begin
      prod = 1;
      for (i = 0; i < count; i++)
        for (j = 0; j < digits[i]; j++) prod = prod * primes[i];
      if (prod % m == tgt) begin
        r.hit = 1'b1;
        r.k = prod[VAL_W-1:0];
        r.cof = VAL_W'(n / prod);
        return r;
      end
      pos = count - 1;
      while (pos >= 0) begin
        if (digits[pos] < powers[pos]) begin
          digits[pos]++;
          break;
        end
        digits[pos] = 0;
        pos--;
      end
      if (pos < 0) return r;
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = expected_matches.size();

  // Predict on each input transfer, compare on each result strobe
  always @(posedge clk) begin
    match_t want;
    if (!rst) begin
      if (start && !busy)
        expected_matches.insert(expected_matches.size(),
                                search_match(prime_value, pair_first, pair_second));
      if (done) begin
        if (expected_matches.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = expected_matches.pop_front();
          if (found !== want.hit)
            report_mismatch($sformatf("found %b, want %b", found, want.hit));
          if (divisor !== want.k)
            report_mismatch($sformatf("divisor %0d, want %0d", divisor, want.k));
          if (cofactor !== want.cof)
            report_mismatch($sformatf("cofactor %0d, want %0d", cofactor, want.cof));
        end
      end
    end
  end

endmodule

>>> sim/pair_divisor_residue_search_unit_test.sv
`timescale 1ns / 1ps
module pair_divisor_residue_search_unit_test;
  import pdrs_pkg::*;

  localparam longint CYCLE_LIMIT = 40_000_000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [31:0]      prime_value = '0;
  logic [5:0]       pair_first = '0;
  logic [5:0]       pair_second = '0;
  logic             busy, done, found;
  logic [VAL_W-1:0] divisor, cofactor;
  int               fail_count, pending;
  longint           cycles = 0;
  bit               burst_mode = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pair_divisor_residue_search_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .prime_value(prime_value), .pair_first(pair_first), .pair_second(pair_second),
    .done(done), .found(found), .divisor(divisor), .cofactor(cofactor)
  );

  pair_divisor_residue_search_checker i_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .prime_value(prime_value), .pair_first(pair_first), .pair_second(pair_second),
    .done(done), .found(found), .divisor(divisor), .cofactor(cofactor),
    .fail_count(fail_count), .pending(pending)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Hold off for a random gap, then present one item until it transfers
  task automatic send_item(input logic [31:0] p, input logic [5:0] a, input logic [5:0] b);
    int gap;
    if ($urandom_range(0, 9) == 0) burst_mode = !burst_mode;
    gap = burst_mode ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    prime_value <= p;
    pair_first <= a;
    pair_second <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Smooth N = r * 2^s with b = 1, so high bits of p are hit without long factoring
  task automatic send_wide_item();
    longint unsigned n, r;
    logic [5:0]      a;
    int              smax, s;
    a = 6'($urandom_range(1, 63));
    r = 64'($urandom_range(1, 255));
    smax = 0;
    while ((r << (smax + 1)) <= 64'hFFFF_FFFF + a) smax++;
    s = $urandom_range((smax > 8) ? smax - 8 : 0, smax);
    n = r << s;
    if (n < a) n = a;
    send_item(32'(n - a), a, 6'd1);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero parameters, zero N, N of one, extremes of every field
    send_item(32'd0, 6'd0, 6'd0);
    send_item(32'd12345, 6'd0, 6'd7);
    send_item(32'd77, 6'd9, 6'd0);
    send_item(32'hFFFF_FFFF, 6'd0, 6'd63);
    send_item(32'd0, 6'd1, 6'd5);
    send_item(32'd0, 6'd63, 6'd63);
    send_item(32'hFFFF_FFFF, 6'd1, 6'd1);
    send_item(32'hFFFF_FFFF, 6'd63, 6'd63);
    send_item(32'd1, 6'd1, 6'd1);
    send_item(32'd2, 6'd1, 6'd2);
    send_item(32'd3, 6'd1, 6'd1);
    send_item(32'd1000, 6'd63, 6'd63);
    send_item(32'd7, 6'd3, 6'd4);
    send_item(32'd997, 6'd1, 6'd1);

    // Drain before carrying on
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // Random: mostly small p for short factoring, some wide smooth items
    for (int i = 0; i < 100; i++) begin
      if ($urandom_range(0, 3) == 0)
        send_wide_item();
      else
        send_item($urandom_range(0, 1023),
                  ($urandom_range(0, 15) == 0) ? 6'd0 : 6'($urandom_range(1, 63)),
                  ($urandom_range(0, 15) == 0) ? 6'd0 : 6'($urandom_range(1, 63)));
    end
    start <= 1'b0;
    @(posedge clk);

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

>>> pair_divisor_residue_search_unit.f
hw/rtl/pdrs_pkg.sv
hw/rtl/pdrs_divider.sv
hw/rtl/pdrs_multiplier.sv
hw/rtl/pdrs_datapath.sv
hw/rtl/pdrs_controller.sv
hw/rtl/pair_divisor_residue_search_unit.sv
sim/pair_divisor_residue_search_checker.sv
sim/pair_divisor_residue_search_unit_test.sv
